### src/tcf_pkg.sv
// shared types, constants and the cordic arctangent table for the tilt filter
package tcf_pkg;

   localparam int ANGLE_WIDTH_DEFAULT = 16;
   localparam int CORDIC_ITER_DEFAULT = 16;
   localparam int ATAN_TABLE_SIZE     = 24;
   localparam int INV_GAIN_Q15        = 19898;
   localparam int CW                  = 28;   // cordic x/y width
   localparam int ZW                  = 26;   // cordic angle width

   localparam logic [15:0] BLEND_RESET  = 16'd32113;
   localparam logic [15:0] PERIOD_RESET = 16'd655;

   localparam logic CSR_BLEND  = 1'b0;
   localparam logic CSR_PERIOD = 1'b1;

   typedef struct packed {
      logic signed [15:0] acc_x;
      logic signed [15:0] acc_y;
      logic signed [15:0] acc_z;
      logic signed [15:0] gyro_roll_rate;
      logic signed [15:0] gyro_pitch_rate;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
   } rsp_payload_type;

   // atan(2^-i) in 1/65536 degree
   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:  r = 26'sd2949120;
         5'd1:  r = 26'sd1740967;
         5'd2:  r = 26'sd919879;
         5'd3:  r = 26'sd466945;
         5'd4:  r = 26'sd234379;
         5'd5:  r = 26'sd117304;
         5'd6:  r = 26'sd58666;
         5'd7:  r = 26'sd29335;
         5'd8:  r = 26'sd14668;
         5'd9:  r = 26'sd7334;
         5'd10: r = 26'sd3667;
         5'd11: r = 26'sd1833;
         5'd12: r = 26'sd917;
         5'd13: r = 26'sd458;
         5'd14: r = 26'sd229;
         5'd15: r = 26'sd115;
         5'd16: r = 26'sd57;
         5'd17: r = 26'sd29;
         5'd18: r = 26'sd14;
         5'd19: r = 26'sd7;
         5'd20: r = 26'sd4;
         5'd21: r = 26'sd2;
         5'd22: r = 26'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // clamp a wide angle to the signed range of w bits (w capped at 16)
   function automatic logic signed [15:0] sat_angle(input logic signed [39:0] v,
                                                    input int w);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      int ww;
      ww = (w > 16) ? 16 : w;
      hi = (40'sd1 <<< (ww - 1)) - 40'sd1;
      lo = -hi - 40'sd1;
      if (v > hi) return hi[15:0];
      if (v < lo) return lo[15:0];
      return v[15:0];
   endfunction

endpackage

### src/tcf_cordic.sv
// iterative cordic vectoring unit, one micro-rotation per cycle
module tcf_cordic import tcf_pkg::*; #(
   parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [CW-1:0] x_in,
   input  logic signed [CW-1:0] y_in,
   output logic                 done,
   output logic signed [CW-1:0] mag,
   output logic signed [ZW-1:0] angle
);
   localparam int STEPS = (CORDIC_ITERATIONS < ATAN_TABLE_SIZE) ?
                          CORDIC_ITERATIONS : ATAN_TABLE_SIZE;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [4:0]           step_ff, step_in;
   logic signed [CW-1:0] x_ff, x_in_r, y_ff, y_in_r;
   logic signed [ZW-1:0] z_ff, z_in;

   // pre-rotation, zero vector and micro-rotation
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in_r  = x_ff;
      y_in_r  = y_ff;
      z_in    = z_ff;
      if (start) begin
         step_in = '0;
         z_in    = '0;
         x_in_r  = x_in;
         y_in_r  = y_in;
         if (x_in == 0 && y_in == 0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            if (x_in < 0) begin
               if (y_in >= 0) begin
                  x_in_r = y_in;
                  y_in_r = -x_in;
                  z_in   = ZW'(90 * 65536);
               end else begin
                  x_in_r = -y_in;
                  y_in_r = x_in;
                  z_in   = -ZW'(90 * 65536);
               end
            end
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_r = x_ff + (y_ff >>> step_ff);
            y_in_r = y_ff - (x_ff >>> step_ff);
            z_in   = z_ff + atan_entry(step_ff);
         end else begin
            x_in_r = x_ff - (y_ff >>> step_ff);
            y_in_r = y_ff + (x_ff >>> step_ff);
            z_in   = z_ff - atan_entry(step_ff);
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff <= x_in_r;
      y_ff <= y_in_r;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign mag   = x_ff;
   assign angle = z_ff;
endmodule

### src/tcf_serial_mult.sv
// shift-add multiplier, one multiplier bit per cycle
module tcf_serial_mult import tcf_pkg::*; #(
   parameter int AW = 32,
   parameter int BW = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic                    done,
   output logic signed [AW+BW-1:0] product
);
   localparam int PW = AW + BW;
   localparam int CNTW = $clog2(BW + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNTW-1:0]      cnt_ff;
   logic signed [PW-1:0] acc_ff;
   logic signed [PW-1:0] mcand_ff;
   logic [BW-1:0]        mplier_ff;

   // two's complement: top bit of b has negative weight
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(BW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= PW'(a);
         mplier_ff <= b;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            if (cnt_ff == CNTW'(BW - 1)) acc_ff <= acc_ff - mcand_ff;
            else acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

### src/tilt_complementary_filter_top.sv
// tilt complementary filter top: sequencer, cordic, serial multiplier, state
// from accept to result valid: two cordic passes, seven serial multiplies and one load into
// the output register; one item in flight, the next item can be taken in the cycle after the
// result is loaded into the output register; a zero cordic vector saves the iterations
// reset (synchronous) clears the estimates to zero, loads blend_weight 32113 and sample_period 655
module tilt_complementary_filter_top import tcf_pkg::*; #(
   parameter int ANGLE_WIDTH       = ANGLE_WIDTH_DEFAULT,
   parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [0:0]      csr_index,
   input  logic [15:0]     csr_data
);
   localparam int MAW = 42;
   localparam int MBW = 17;
   localparam int MPW = MAW + MBW;

   typedef enum logic [3:0] {
      S_IDLE, S_CROLL, S_MGAIN, S_CPITCH, S_PROP_R, S_MW1_R, S_MW2_R,
      S_PROP_P, S_MW1_P, S_MW2_P, S_OUT
   } state_type;

   state_type state_ff;
   logic [15:0] blend_ff, period_ff;
   logic signed [15:0] roll_est_ff, pitch_est_ff;
   req_payload_type req_ff;
   logic signed [15:0] acc_roll_ff, acc_pitch_ff;
   logic signed [MPW-1:0] part_ff;
   logic rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic c_start, c_done;
   logic signed [CW-1:0] c_x, c_y, c_mag;
   logic signed [ZW-1:0] c_ang;
   logic m_start, m_done;
   logic signed [MAW-1:0] m_a;
   logic signed [MBW-1:0] m_b;
   logic signed [MPW-1:0] m_p;

   logic signed [16:0] alpha_c, one_minus;
   logic signed [15:0] acc_cur, est_cur, rate_cur, accel_q;
   logic signed [15:0] blend_w;

   tcf_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock, .reset, .start(c_start), .x_in(c_x), .y_in(c_y),
      .done(c_done), .mag(c_mag), .angle(c_ang)
   );

   tcf_serial_mult #(.AW(MAW), .BW(MBW)) u_mult (
      .clock, .reset, .start(m_start), .a(m_a), .b(m_b),
      .done(m_done), .product(m_p)
   );

   // clamp weight, scale the cordic angle, pick the channel and round the blended sum
   always_comb begin
      alpha_c   = (blend_ff > 16'd32768) ? 17'sd32768 : $signed({1'b0, blend_ff});
      one_minus = 17'sd32768 - alpha_c;
      accel_q   = sat_angle(40'((c_ang + 26'sd256) >>> 9), ANGLE_WIDTH);
      if (state_ff == S_PROP_R || state_ff == S_MW1_R || state_ff == S_MW2_R) begin
         acc_cur  = acc_roll_ff;
         est_cur  = roll_est_ff;
         rate_cur = req_ff.gyro_roll_rate;
      end else begin
         acc_cur  = acc_pitch_ff;
         est_cur  = pitch_est_ff;
         rate_cur = req_ff.gyro_pitch_rate;
      end
      blend_w = sat_angle(40'((part_ff + m_p + (MPW'(1) <<< 27)) >>> 28), ANGLE_WIDTH);
   end

   // operand selection for the shared units
   always_comb begin
      c_start = 1'b0;
      c_x     = '0;
      c_y     = '0;
      m_start = 1'b0;
      m_a     = '0;
      m_b     = '0;
      case (state_ff)
         S_IDLE: begin
            c_start = req_valid;
            c_x     = CW'(req_data.acc_z) <<< 8;
            c_y     = CW'(req_data.acc_y) <<< 8;
         end
         S_CROLL: begin
            m_start = c_done;
            m_a     = MAW'(c_mag);
            m_b     = MBW'(INV_GAIN_Q15);
         end
         S_MGAIN: begin
            c_start = m_done;
            c_x     = CW'(m_p >>> 15);
            c_y     = -(CW'(req_ff.acc_x) <<< 8);
         end
         S_CPITCH: begin
            m_start = c_done;
            m_a     = MAW'(req_ff.gyro_roll_rate);
            m_b     = $signed({1'b0, period_ff});
         end
         S_PROP_R, S_PROP_P: begin
            m_start = m_done;
            m_a     = MAW'(m_p) + (MAW'(est_cur) <<< 13);
            m_b     = alpha_c;
         end
         S_MW1_R, S_MW1_P: begin
            m_start = m_done;
            m_a     = MAW'(acc_cur) <<< 13;
            m_b     = one_minus;
         end
         S_MW2_R: begin
            m_start = m_done;
            m_a     = MAW'(req_ff.gyro_pitch_rate);
            m_b     = $signed({1'b0, period_ff});
         end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         blend_ff     <= BLEND_RESET;
         period_ff    <= PERIOD_RESET;
         roll_est_ff  <= '0;
         pitch_est_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               CSR_BLEND:  blend_ff  <= csr_data;
               CSR_PERIOD: period_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE:   if (req_valid) state_ff <= S_CROLL;
            S_CROLL:  if (c_done) state_ff <= S_MGAIN;
            S_MGAIN:  if (m_done) state_ff <= S_CPITCH;
            S_CPITCH: if (c_done) state_ff <= S_PROP_R;
            S_PROP_R: if (m_done) state_ff <= S_MW1_R;
            S_MW1_R:  if (m_done) state_ff <= S_MW2_R;
            S_MW2_R: begin
               if (m_done) begin
                  roll_est_ff <= blend_w;
                  state_ff    <= S_PROP_P;
               end
            end
            S_PROP_P: if (m_done) state_ff <= S_MW1_P;
            S_MW1_P:  if (m_done) state_ff <= S_MW2_P;
            S_MW2_P: begin
               if (m_done) begin
                  pitch_est_ff <= blend_w;
                  state_ff     <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      // payload registers
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == S_CROLL && c_done) acc_roll_ff <= accel_q;
      if (state_ff == S_CPITCH && c_done) acc_pitch_ff <= accel_q;
      if ((state_ff == S_MW1_R || state_ff == S_MW1_P) && m_done) part_ff <= m_p;
      if (state_ff == S_MW2_R && m_done) part_ff <= part_ff + m_p;
      if (state_ff == S_MW2_P && m_done) part_ff <= part_ff + m_p;
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.roll_angle  <= roll_est_ff;
         rsp_ff.pitch_angle <= pitch_est_ff;
      end
   end
endmodule
